/* design/bhs_pkg.sv */
// Package for the bucketed hash set: field widths, parameter defaults,
// the request code type, the back-end state type and an index-width helper.
// No dependencies.
`timescale 1ns / 1ps

package bhs_pkg;

   localparam int ACTION_BITS  = 2;
   localparam int KEY_IN_BITS  = 32;
   localparam int FILL_BITS    = 4;
   localparam int SLOTS_DEF    = 8;
   localparam int BUCKETS_DEF  = 16;
   localparam int KEY_BITS_DEF = 32;
   localparam int QUEUE_DEPTH  = 2;

   // Request codes; the unused code is treated as a find.
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_FIND   = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_ERASE  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_FETCH,
      ST_UPDATE
   } back_state_type;

   // Address width for a table of n entries; never less than one bit.
   function automatic int idx_bits(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

/* design/bhs_if.sv */
// Channel interfaces of the bucketed hash set: request and response.
// Depends on bhs_pkg.
`timescale 1ns / 1ps

interface bhs_req_if;
   import bhs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ACTION_BITS-1:0] action;
   logic [KEY_IN_BITS-1:0] key;

   modport source (output valid, output action, output key, input ready);
   modport sink   (input valid, input action, input key, output ready);
endinterface

interface bhs_rsp_if;
   import bhs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 present_before;
   logic                 changed;
   logic                 bucket_full;
   logic [FILL_BITS-1:0] bucket_fill;

   modport source (output valid, output present_before, output changed,
                   output bucket_full, output bucket_fill, input ready);
   modport sink   (input valid, input present_before, input changed,
                   input bucket_full, input bucket_fill, output ready);
endinterface

/* design/bhs_front.sv */
// Front end of the bucketed hash set: takes requests, masks the key,
// picks the bucket and classifies the request code into one register stage.
// Depends on bhs_pkg and bhs_if.
`timescale 1ns / 1ps

module bhs_front #(
   parameter int NUM_BUCKETS = bhs_pkg::BUCKETS_DEF,
   parameter int KEY_BITS    = bhs_pkg::KEY_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         clear_busy,
   bhs_req_if.sink                                      req_ch,
   output logic                                         fe_valid,
   input  logic                                         fe_ready,
   output bhs_pkg::action_type                          fe_action,
   output logic [bhs_pkg::idx_bits(NUM_BUCKETS)-1:0]    fe_bucket,
   output logic [KEY_BITS-1:0]                          fe_key
);
   import bhs_pkg::*;

   localparam int BKT_BITS  = idx_bits(NUM_BUCKETS);
   localparam int KEY_USE   = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
   localparam int WIDE_BITS = (KEY_BITS > BKT_BITS) ? KEY_BITS : BKT_BITS;

   logic [KEY_BITS-1:0]  key_masked;
   logic [WIDE_BITS-1:0] key_wide;
   logic [BKT_BITS-1:0]  bucket;
   action_type           act_class;
   logic                 take;

   logic                 valid_ff, valid_in;
   action_type           action_ff;
   logic [BKT_BITS-1:0]  bucket_ff;
   logic [KEY_BITS-1:0]  key_ff;

   assign req_ch.ready = !clear_busy && (!valid_ff || fe_ready);
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      key_masked = KEY_BITS'(req_ch.key[KEY_USE-1:0]);
      key_wide   = WIDE_BITS'(key_masked);
      // The bucket count must be a power of two (not enforced here); the modulo is then the low bits.
      bucket     = (NUM_BUCKETS > 1) ? key_wide[BKT_BITS-1:0] : '0;
   end

   always_comb begin
      unique case (req_ch.action)
         ACT_FIND:   act_class = ACT_FIND;
         ACT_INSERT: act_class = ACT_INSERT;
         ACT_ERASE:  act_class = ACT_ERASE;
         default:    act_class = ACT_FIND;
      endcase
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (fe_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         action_ff <= act_class;
         bucket_ff <= bucket;
         key_ff    <= key_masked;
      end
   end

   assign fe_valid  = valid_ff;
   assign fe_action = action_ff;
   assign fe_bucket = bucket_ff;
   assign fe_key    = key_ff;

endmodule

/* design/bhs_queue.sv */
// Short first-in first-out queue between the front and back ends.
// Depends on bhs_pkg for its default depth.
`timescale 1ns / 1ps

module bhs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bhs_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import bhs_pkg::*;

   localparam int PTR_BITS = idx_bits(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != CNT_BITS'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* design/bhs_back.sv */
// Back end of the bucketed hash set: bucket memory, clearing pass after
// reset, read-modify-write of one bucket row per request, response register.
// Depends on bhs_pkg and bhs_if.
`timescale 1ns / 1ps

module bhs_back #(
   parameter int SLOTS_PER_BUCKET = bhs_pkg::SLOTS_DEF,
   parameter int NUM_BUCKETS      = bhs_pkg::BUCKETS_DEF,
   parameter int KEY_BITS         = bhs_pkg::KEY_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   output logic                                      clear_busy,
   input  logic                                      q_valid,
   output logic                                      q_ready,
   input  bhs_pkg::action_type                       q_action,
   input  logic [bhs_pkg::idx_bits(NUM_BUCKETS)-1:0] q_bucket,
   input  logic [KEY_BITS-1:0]                       q_key,
   bhs_rsp_if.source                                 rsp_ch
);
   import bhs_pkg::*;

   localparam int BKT_BITS  = idx_bits(NUM_BUCKETS);
   localparam int CNT_BITS  = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int SLOT_BITS = SLOTS_PER_BUCKET * KEY_BITS;
   localparam int ROW_BITS  = CNT_BITS + SLOT_BITS;

   // Each row holds a bucket's fill count above its slots.
   logic [ROW_BITS-1:0] row_mem [NUM_BUCKETS];
   logic [ROW_BITS-1:0] rd_row_ff;

   back_state_type      state_ff, state_in;
   logic [BKT_BITS-1:0] clr_idx_ff, clr_idx_in;
   action_type          action_ff;
   logic [BKT_BITS-1:0] bucket_ff;
   logic [KEY_BITS-1:0] key_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 present_ff, changed_ff, full_ff;
   logic [FILL_BITS-1:0] fill_ff;

   logic                 fetch_go, update_go, out_free, clr_we;
   logic                 mem_we;
   logic [BKT_BITS-1:0]  mem_addr;
   logic [ROW_BITS-1:0]  mem_wdata;

   logic [SLOTS_PER_BUCKET-1:0][KEY_BITS-1:0] slots_old, slots_new;
   logic [CNT_BITS-1:0]                       cnt_old, cnt_new;
   logic [SLOTS_PER_BUCKET-1:0]               match, at_or_after;
   logic                                      found, changed, full;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == BKT_BITS'(NUM_BUCKETS - 1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (q_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_FETCH;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // State outputs.
   always_comb begin
      clear_busy = 1'b0;
      q_ready    = 1'b0;
      clr_we     = 1'b0;
      update_go  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_busy = 1'b1;
            clr_we     = 1'b1;
         end
         ST_FETCH: begin
            q_ready = 1'b1;
         end
         ST_UPDATE: begin
            update_go = out_free;
         end
         default: begin
            clear_busy = 1'b1;
         end
      endcase
   end

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign fetch_go   = q_ready && q_valid;
   assign clr_idx_in = clr_we ? clr_idx_ff + BKT_BITS'(1) : clr_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_go) begin
         action_ff <= q_action;
         bucket_ff <= q_bucket;
         key_ff    <= q_key;
      end
   end

   // Search the fetched row and build its new contents.
   always_comb begin
      cnt_old   = rd_row_ff[ROW_BITS-1 -: CNT_BITS];
      slots_old = rd_row_ff[SLOT_BITS-1:0];
      for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
         match[i] = (CNT_BITS'(i) < cnt_old) && (slots_old[i] == key_ff);
      end
      found = |match;
      // Slots from the matching one upward take their upper neighbor on erase.
      at_or_after[0] = match[0];
      for (int i = 1; i < SLOTS_PER_BUCKET; i++) begin
         at_or_after[i] = at_or_after[i-1] | match[i];
      end

      slots_new = slots_old;
      cnt_new   = cnt_old;
      changed   = 1'b0;
      full      = 1'b0;
      case (action_ff)
         ACT_INSERT: begin
            if (!found) begin
               if (cnt_old == CNT_BITS'(SLOTS_PER_BUCKET)) begin
                  full = 1'b1;
               end else begin
                  for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
                     if (CNT_BITS'(i) == cnt_old) begin
                        slots_new[i] = key_ff;
                     end
                  end
                  cnt_new = cnt_old + CNT_BITS'(1);
                  changed = 1'b1;
               end
            end
         end
         ACT_ERASE: begin
            if (found) begin
               for (int i = 0; i < SLOTS_PER_BUCKET - 1; i++) begin
                  if (at_or_after[i]) begin
                     slots_new[i] = slots_old[i+1];
                  end
               end
               cnt_new = cnt_old - CNT_BITS'(1);
               changed = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign mem_we    = clr_we || update_go;
   assign mem_addr  = clr_we ? clr_idx_ff : bucket_ff;
   assign mem_wdata = clr_we ? '0 : {cnt_new, slots_new};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_addr] <= mem_wdata;
      end
      if (fetch_go) begin
         rd_row_ff <= row_mem[q_bucket];
      end
   end

   // Response register.
   always_comb begin
      if (update_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update_go) begin
         present_ff <= found;
         changed_ff <= changed;
         full_ff    <= full;
         fill_ff    <= FILL_BITS'(cnt_new);
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.present_before = present_ff;
   assign rsp_ch.changed        = changed_ff;
   assign rsp_ch.bucket_full    = full_ff;
   assign rsp_ch.bucket_fill    = fill_ff;

endmodule

/* design/bucketed_hash_set.sv */
// Top level of the bucketed hash set: front end, queue and back end.
// Depends on bhs_pkg, bhs_if, bhs_front, bhs_queue and bhs_back.
//
//   Channel   Direction   Transfer
//   req_ch    in          one request: action, key
//   rsp_ch    out         one response: present_before, changed,
//                         bucket_full, bucket_fill
//
// Each request passes the back-end states ST_FETCH, which reads its bucket
// row from the bucket memory, and ST_UPDATE, which compares all slots, writes
// the row back and loads the response register once that register is free;
// the back end fetches no new request until ST_UPDATE is done. After reset a
// clearing pass zeroes every bucket's fill count, during which req_ch.ready
// stays low.
// A stalled response holds only the back end; the front register and the
// queue keep taking requests until they fill.
`timescale 1ns / 1ps

module bucketed_hash_set #(
   parameter int SLOTS_PER_BUCKET = bhs_pkg::SLOTS_DEF,
   parameter int NUM_BUCKETS      = bhs_pkg::BUCKETS_DEF,
   parameter int KEY_BITS         = bhs_pkg::KEY_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bhs_req_if.sink   req_ch,
   bhs_rsp_if.source rsp_ch
);
   import bhs_pkg::*;

   localparam int BKT_BITS = idx_bits(NUM_BUCKETS);
   localparam int Q_WIDTH  = ACTION_BITS + BKT_BITS + KEY_BITS;

   logic                clear_busy;

   // Classified request from the front end.
   logic                fe_valid, fe_ready;
   action_type          fe_action;
   logic [BKT_BITS-1:0] fe_bucket;
   logic [KEY_BITS-1:0] fe_key;

   // Queue head toward the back end.
   logic                q_valid, q_ready;
   logic [Q_WIDTH-1:0]  q_data;
   action_type          q_action;
   logic [BKT_BITS-1:0] q_bucket;
   logic [KEY_BITS-1:0] q_key;

   bhs_front #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .KEY_BITS    (KEY_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .req_ch     (req_ch),
      .fe_valid   (fe_valid),
      .fe_ready   (fe_ready),
      .fe_action  (fe_action),
      .fe_bucket  (fe_bucket),
      .fe_key     (fe_key)
   );

   bhs_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_data   ({fe_action, fe_bucket, fe_key}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   assign q_action = action_type'(q_data[Q_WIDTH-1 -: ACTION_BITS]);
   assign q_bucket = q_data[KEY_BITS +: BKT_BITS];
   assign q_key    = q_data[KEY_BITS-1:0];

   bhs_back #(
      .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
      .NUM_BUCKETS      (NUM_BUCKETS),
      .KEY_BITS         (KEY_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_action   (q_action),
      .q_bucket   (q_bucket),
      .q_key      (q_key),
      .rsp_ch     (rsp_ch)
   );

endmodule

/* test/bhs_tb_pkg.sv */
// Scoreboard for the bucketed hash set testbench: predicts each response
// from the requests it is given and checks the responses the block returns.
// Depends on bhs_pkg.
`timescale 1ns / 1ps

package bhs_tb_pkg;
   import bhs_pkg::*;

   // The spare request code, which the block treats as a find.
   localparam logic [ACTION_BITS-1:0] ACT_SPARE = 2'd3;
   localparam int SLOTS        = SLOTS_DEF;
   localparam int BUCKETS      = BUCKETS_DEF;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                 present_before;
      logic                 changed;
      logic                 bucket_full;
      logic [FILL_BITS-1:0] bucket_fill;
   } set_response_type;

   class hash_set_scoreboard;
      logic [KEY_IN_BITS-1:0] stored_keys [BUCKETS][SLOTS];
      int unsigned            fill_counts [BUCKETS];
      set_response_type       expected_responses [$];
      int unsigned            mismatches;

      function new();
         foreach (fill_counts[b]) fill_counts[b] = 0;
         mismatches = 0;
      endfunction

      // Applies one accepted request to the shadow table and queues the
      // response that the block owes for it.
      function void predict_request(input logic [ACTION_BITS-1:0] action,
                                    input logic [KEY_IN_BITS-1:0] key);
         set_response_type resp;
         int unsigned      bucket;
         int unsigned      fill;
         int unsigned      pos;
         bit               found;
         bucket = key % BUCKETS;
         fill   = fill_counts[bucket];
         found  = 1'b0;
         pos    = 0;
         for (int i = 0; i < fill; i++) begin
            if (!found && stored_keys[bucket][i] == key) begin
               found = 1'b1;
               pos   = i;
            end
         end
         resp = '0;
         resp.present_before = found;
         case (action)
            ACT_INSERT: begin
               if (!found) begin
                  if (fill >= SLOTS) begin
                     resp.bucket_full = 1'b1;
                  end else begin
                     stored_keys[bucket][fill] = key;
                     fill++;
                     resp.changed = 1'b1;
                  end
               end
            end
            ACT_ERASE: begin
               if (found) begin
                  for (int i = pos; i + 1 < fill; i++)
                     stored_keys[bucket][i] = stored_keys[bucket][i + 1];
                  fill--;
                  resp.changed = 1'b1;
               end
            end
            default: ;
         endcase
         fill_counts[bucket] = fill;
         resp.bucket_fill = FILL_BITS'(fill);
         expected_responses.push_back(resp);
      endfunction

      function void check_response(input set_response_type got);
         set_response_type want;
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response with none outstanding: %p", $realtime, got);
            return;
         end
         want = expected_responses.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: response differs from prediction", $realtime);
               $display("   present_before exp %b got %b",
                        want.present_before, got.present_before);
               $display("   changed        exp %b got %b", want.changed, got.changed);
               $display("   bucket_full    exp %b got %b",
                        want.bucket_full, got.bucket_full);
               $display("   bucket_fill    exp %0d got %0d",
                        want.bucket_fill, got.bucket_fill);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_responses.size();
      endfunction
   endclass

endpackage

/* test/tb_bucketed_hash_set.sv */
// Self-checking testbench for bucketed_hash_set: directed and random
// find, insert and erase requests, checked against a shadow hash table.
// Depends on bhs_pkg, bhs_if, bhs_tb_pkg and the bucketed_hash_set RTL.
`timescale 1ns / 1ps

module tb_bucketed_hash_set;
   import bhs_pkg::*;
   import bhs_tb_pkg::*;

   localparam int RANDOM_ITEMS    = 600;
   localparam int IDLE_PERCENT    = 12;
   localparam int HOLD_OFF_CYCLES = 100;
   // Allow a generous margin for stray responses before declaring the run finished.
   localparam int DRAIN_CYCLES    = 16;
   // Longest correct quiet spell is the receiver hold-off plus the clearing
   // pass after reset, both well under this.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int POOL_SIZE       = 40;

   logic clock = 1'b0;
   logic reset;

   bhs_req_if req_ch ();
   bhs_rsp_if rsp_ch ();

   bucketed_hash_set dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   hash_set_scoreboard board;

   // Shared between the request and response processes. While steady is
   // set neither side inserts idle cycles; hold_request asks the receiver
   // for its single long hold-off.
   bit          steady;
   bit          hold_request;
   bit          hold_done;
   int unsigned quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor and watchdog. Both channels are sampled at the rising edge, so
   // a transfer is seen exactly when valid and ready were high before it.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            board.predict_request(req_ch.action, req_ch.key);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_response({rsp_ch.present_before, rsp_ch.changed,
                                  rsp_ch.bucket_full, rsp_ch.bucket_fill});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Response receiver. Ready drops at random about one cycle in eight,
   // except during the steady stretch. Once asked, it holds ready low for a
   // long stretch so that the front register and queue fill and the block
   // has to stall its request channel.
   initial begin
      rsp_ch.ready = 1'b0;
      hold_done    = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Offers one request and returns at the edge where it transfers. Any
   // idle cycles come first, so a gap can follow any transfer; when there
   // is none, valid simply stays high into the next request.
   task automatic send_request(input logic [ACTION_BITS-1:0] action,
                               input logic [KEY_IN_BITS-1:0] key);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= action;
      req_ch.key    <= key;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin
      logic [KEY_IN_BITS-1:0] key_pool [POOL_SIZE];
      logic [ACTION_BITS-1:0] action;
      logic [KEY_IN_BITS-1:0] key;
      int unsigned            pick;

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.action = ACT_FIND;
      req_ch.key    = '0;
      steady        = 1'b0;
      hold_request  = 1'b0;
      board         = new();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Bucket 0 is filled to capacity with keys whose low
      // nibble is zero, which lets the full, slot-zero and middle-slot
      // cases be hit in a known order.
      send_request(ACT_FIND, 32'h0000_0000);       // lookup in an empty table
      send_request(ACT_INSERT, 32'h0000_0000);     // smallest key
      send_request(ACT_INSERT, 32'hFFFF_FFFF);     // largest key, last bucket
      send_request(ACT_FIND, 32'hFFFF_FFFF);
      send_request(ACT_INSERT, 32'h0000_0000);     // insert of a present key
      for (int i = 1; i < SLOTS; i++)
         send_request(ACT_INSERT, 32'(i) << 4);
      send_request(ACT_INSERT, 32'hAAAA_AAA0);     // refused, bucket is full
      send_request(ACT_FIND, 32'h0000_0070);       // hit in the last slot
      send_request(ACT_SPARE, 32'h0000_0030);      // spare code acts as find
      send_request(ACT_ERASE, 32'h0000_0000);      // key held in slot zero
      send_request(ACT_ERASE, 32'h0000_0040);      // key in a middle slot
      send_request(ACT_ERASE, 32'h5555_5550);      // absent key
      send_request(ACT_INSERT, 32'h5555_5550);     // reuses a freed slot
      send_request(ACT_ERASE, 32'hFFFF_FFFF);      // empties the last bucket
      send_request(ACT_ERASE, 32'hFFFF_FFFF);      // erase from an empty bucket
      send_request(ACT_FIND, 32'h0000_0000);       // gone after the erase

      // Most random keys come from a small pool spread over four buckets,
      // about ten keys per bucket, so buckets fill, overflow and drain
      // repeatedly. The rest are fully random keys over the whole range.
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = ($urandom() & 32'hFFFF_FFF0) | 32'(i % 4);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 250 && n < 400);
         if (n == 120)
            hold_request = 1'b1;
         pick = $urandom_range(99);
         if (pick < 45)
            action = ACT_INSERT;
         else if (pick < 70)
            action = ACT_ERASE;
         else if (pick < 95)
            action = ACT_FIND;
         else
            action = ACT_SPARE;
         if ($urandom_range(99) < 80)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else
            key = $urandom();
         send_request(action, key);
      end
      req_ch.valid <= 1'b0;

      // Wait for every predicted response, then linger in case the block
      // sends anything it should not.
      do @(posedge clock); while (board.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* bucketed_hash_set.f */
design/bhs_pkg.sv
design/bhs_if.sv
design/bhs_front.sv
design/bhs_queue.sv
design/bhs_back.sv
design/bucketed_hash_set.sv
test/bhs_tb_pkg.sv
test/tb_bucketed_hash_set.sv
